[rtl/core/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high, with a fixed message
`define SPS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: %m");

// same, with a caller supplied message
`define SPS_ASSERT_MSG(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

`endif

[rtl/core/sps_pkg.sv]
// types and constants of the seven-point stencil matrix-vector block
package sps_pkg;

   localparam int DATA_W    = 32;
   localparam int COORD_W   = 4;
   localparam int CNT_W     = 5;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W    = 2 * DATA_W;
   // seven products of 64 bits need three guard bits
   localparam int ACC_W     = PROD_W + 3;
   localparam int FRAC_W    = 16;
   localparam int RND_W     = ACC_W - FRAC_W;

   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_COMPUTE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_Z = 2'd2;

   localparam logic [CNT_W-1:0] GRID_RESET = 5'd16;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);
   localparam logic signed [RND_W-1:0] SAT_MAX    = RND_W'(64'sh7fffffff);
   localparam logic signed [RND_W-1:0] SAT_MIN    = -RND_W'(64'sh80000000);
   localparam logic [DATA_W-1:0]       RAIL_MAX   = 32'h7fffffff;
   localparam logic [DATA_W-1:0]       RAIL_MIN   = 32'h80000000;

   // stencil points in read order
   typedef enum logic [2:0] {
      STEP_CENTER,
      STEP_XP,
      STEP_YP,
      STEP_ZP,
      STEP_XM,
      STEP_YM,
      STEP_ZM
   } step_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_READ,
      ST_DRAIN,
      ST_ROUND,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic     capture;
      logic     write_cell;
      logic     out_direct;
      logic     acc_clear;
      logic     issue;
      step_type step;
      logic     round_en;
      logic     out_result;
   } ctrl_cmd_type;

   typedef struct packed {
      logic in_grid;
      logic is_load;
   } dp_status_type;

endpackage

[rtl/core/sps_channels.sv]
// channel interfaces: request, response and register write
interface sps_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [3:0]  x_coord;
   logic [3:0]  y_coord;
   logic [3:0]  z_coord;
   logic signed [31:0] cell_value;
   logic signed [31:0] diag_coef;
   logic signed [31:0] up_x_coef;
   logic signed [31:0] up_y_coef;
   logic signed [31:0] up_z_coef;

   modport source (
      output valid, func, x_coord, y_coord, z_coord,
             cell_value, diag_coef, up_x_coef, up_y_coef, up_z_coef,
      input  ready
   );
   modport sink (
      input  valid, func, x_coord, y_coord, z_coord,
             cell_value, diag_coef, up_x_coef, up_y_coef, up_z_coef,
      output ready
   );
endinterface

interface sps_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] product_value;
   logic [1:0]  status;

   modport source (output valid, product_value, status, input ready);
   modport sink   (input valid, product_value, status, output ready);
endinterface

interface sps_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [4:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/sps_ctrl.sv]
// controller state machine: sequences loads, stencil reads and result hand-off
module sps_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  sps_pkg::dp_status_type stat,
   output sps_pkg::ctrl_cmd_type  cmd
);
   import sps_pkg::*;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      drain_ff, drain_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_CENTER;
         drain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      drain_in  = drain_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.step  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!stat.in_grid || stat.is_load) begin
               if (out_free) begin
                  cmd.out_direct = 1'b1;
                  cmd.write_cell = stat.in_grid && stat.is_load;
                  state_in       = ST_IDLE;
               end
            end else begin
               cmd.acc_clear = 1'b1;
               step_in       = STEP_CENTER;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            cmd.issue = 1'b1;
            if (step_ff == STEP_ZM) begin
               step_in  = STEP_CENTER;
               drain_in = 1'b0;
               state_in = ST_DRAIN;
            end else begin
               step_in = step_type'(step_ff + 3'd1);
            end
         end
         ST_DRAIN: begin
            // read data stage, then product stage
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_result = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || cmd.out_direct || cmd.out_result;
   end

endmodule

[rtl/core/sps_dp.sv]
// datapath: grid stores, neighbor addressing, multiply-accumulate, rounding, result register
module sps_dp #(
   parameter int MAX_X = 16,
   parameter int MAX_Y = 16,
   parameter int MAX_Z = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sps_pkg::ctrl_cmd_type                cmd,
   output sps_pkg::dp_status_type               stat,
   input  logic                                 csr_write,
   input  logic [sps_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [sps_pkg::CNT_W-1:0]            csr_data,
   input  logic                                 req_func,
   input  logic [sps_pkg::COORD_W-1:0]          req_x_coord,
   input  logic [sps_pkg::COORD_W-1:0]          req_y_coord,
   input  logic [sps_pkg::COORD_W-1:0]          req_z_coord,
   input  logic signed [sps_pkg::DATA_W-1:0]    req_cell_value,
   input  logic signed [sps_pkg::DATA_W-1:0]    req_diag_coef,
   input  logic signed [sps_pkg::DATA_W-1:0]    req_up_x_coef,
   input  logic signed [sps_pkg::DATA_W-1:0]    req_up_y_coef,
   input  logic signed [sps_pkg::DATA_W-1:0]    req_up_z_coef,
   output logic signed [sps_pkg::DATA_W-1:0]    rsp_product_value,
   output logic [sps_pkg::STATUS_W-1:0]         rsp_status
);
   import sps_pkg::*;

   localparam int CELLS    = MAX_X * MAX_Y * MAX_Z;
   localparam int ADDR_W   = $clog2(CELLS);
   localparam int STRIDE_Y = MAX_Z;
   localparam int STRIDE_X = MAX_Y * MAX_Z;
   localparam logic [ADDR_W-1:0] OFF_X = ADDR_W'(STRIDE_X);
   localparam logic [ADDR_W-1:0] OFF_Y = ADDR_W'(STRIDE_Y);
   localparam logic [ADDR_W-1:0] OFF_Z = ADDR_W'(1);

   logic [CNT_W-1:0] grid_x_ff, grid_y_ff, grid_z_ff;

   logic                      func_ff;
   logic [COORD_W-1:0]        x_ff, y_ff, z_ff;
   logic signed [DATA_W-1:0]  val_ff, diag_ff, upx_ff, upy_ff, upz_ff;

   logic signed [DATA_W-1:0]  vec_mem  [CELLS];
   logic signed [DATA_W-1:0]  diag_mem [CELLS];
   logic signed [DATA_W-1:0]  upx_mem  [CELLS];
   logic signed [DATA_W-1:0]  upy_mem  [CELLS];
   logic signed [DATA_W-1:0]  upz_mem  [CELLS];

   logic signed [DATA_W-1:0]  rd_vec_ff, rd_diag_ff, rd_upx_ff, rd_upy_ff, rd_upz_ff;
   logic signed [DATA_W-1:0]  upx_c_ff, upy_c_ff, upz_c_ff;
   logic                      rd_valid_ff, rd_term_ff, mult_valid_ff;
   step_type                  rd_step_ff;

   logic signed [PROD_W-1:0]  product_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [RND_W-1:0]   rnd_ff;
   logic signed [DATA_W-1:0]  out_value_ff;
   logic [STATUS_W-1:0]       out_status_ff;

   logic                      x_ok, y_ok, z_ok;
   logic                      xp_ok, yp_ok, zp_ok;
   logic                      term_ok;
   logic [ADDR_W-1:0]         cell_addr, rd_addr;
   logic signed [DATA_W-1:0]  op_coef;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_x_ff <= GRID_RESET;
         grid_y_ff <= GRID_RESET;
         grid_z_ff <= GRID_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_GRID_X: grid_x_ff <= csr_data;
            CSR_GRID_Y: grid_y_ff <= csr_data;
            CSR_GRID_Z: grid_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         x_ff    <= req_x_coord;
         y_ff    <= req_y_coord;
         z_ff    <= req_z_coord;
         val_ff  <= req_cell_value;
         diag_ff <= req_diag_coef;
         upx_ff  <= req_up_x_coef;
         upy_ff  <= req_up_y_coef;
         upz_ff  <= req_up_z_coef;
      end
   end

   // a count above the parameter acts as the parameter
   always_comb begin
      x_ok  = ({1'b0, x_ff} < grid_x_ff) && (int'(x_ff) < MAX_X);
      y_ok  = ({1'b0, y_ff} < grid_y_ff) && (int'(y_ff) < MAX_Y);
      z_ok  = ({1'b0, z_ff} < grid_z_ff) && (int'(z_ff) < MAX_Z);
      xp_ok = ({1'b0, x_ff} + 5'd1 < grid_x_ff) && (int'(x_ff) + 1 < MAX_X);
      yp_ok = ({1'b0, y_ff} + 5'd1 < grid_y_ff) && (int'(y_ff) + 1 < MAX_Y);
      zp_ok = ({1'b0, z_ff} + 5'd1 < grid_z_ff) && (int'(z_ff) + 1 < MAX_Z);
   end

   assign stat.in_grid = x_ok && y_ok && z_ok;
   assign stat.is_load = (func_ff == FUNC_LOAD);

   assign cell_addr = ADDR_W'(int'(x_ff) * STRIDE_X + int'(y_ff) * STRIDE_Y + int'(z_ff));

   // neighbors off the grid read the center and add nothing
   always_comb begin
      unique case (cmd.step)
         STEP_CENTER: term_ok = 1'b1;
         STEP_XP:     term_ok = xp_ok;
         STEP_YP:     term_ok = yp_ok;
         STEP_ZP:     term_ok = zp_ok;
         STEP_XM:     term_ok = (x_ff != '0);
         STEP_YM:     term_ok = (y_ff != '0);
         STEP_ZM:     term_ok = (z_ff != '0);
         default:     term_ok = 1'b0;
      endcase
      rd_addr = cell_addr;
      if (term_ok) begin
         unique case (cmd.step)
            STEP_XP: rd_addr = cell_addr + OFF_X;
            STEP_YP: rd_addr = cell_addr + OFF_Y;
            STEP_ZP: rd_addr = cell_addr + OFF_Z;
            STEP_XM: rd_addr = cell_addr - OFF_X;
            STEP_YM: rd_addr = cell_addr - OFF_Y;
            STEP_ZM: rd_addr = cell_addr - OFF_Z;
            default: rd_addr = cell_addr;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_cell) begin
         vec_mem[cell_addr]  <= val_ff;
         diag_mem[cell_addr] <= diag_ff;
         upx_mem[cell_addr]  <= upx_ff;
         upy_mem[cell_addr]  <= upy_ff;
         upz_mem[cell_addr]  <= upz_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_vec_ff  <= vec_mem[rd_addr];
      rd_diag_ff <= diag_mem[rd_addr];
      rd_upx_ff  <= upx_mem[rd_addr];
      rd_upy_ff  <= upy_mem[rd_addr];
      rd_upz_ff  <= upz_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         rd_term_ff    <= 1'b0;
         rd_step_ff    <= STEP_CENTER;
         mult_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff   <= cmd.issue;
         rd_term_ff    <= cmd.issue && term_ok;
         rd_step_ff    <= cmd.step;
         mult_valid_ff <= rd_valid_ff && rd_term_ff;
      end
   end

   // upward coefficients of the center cell serve the three upper neighbors
   always_ff @(posedge clock) begin
      if (rd_valid_ff && rd_step_ff == STEP_CENTER) begin
         upx_c_ff <= rd_upx_ff;
         upy_c_ff <= rd_upy_ff;
         upz_c_ff <= rd_upz_ff;
      end
   end

   always_comb begin
      case (rd_step_ff)
         STEP_CENTER: op_coef = rd_diag_ff;
         STEP_XP:     op_coef = upx_c_ff;
         STEP_YP:     op_coef = upy_c_ff;
         STEP_ZP:     op_coef = upz_c_ff;
         STEP_XM:     op_coef = rd_upx_ff;
         STEP_YM:     op_coef = rd_upy_ff;
         STEP_ZM:     op_coef = rd_upz_ff;
         default:     op_coef = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      product_ff <= op_coef * rd_vec_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (mult_valid_ff) begin
         acc_ff <= acc_ff + ACC_W'(product_ff);
      end
   end

   // round half up from Q32.32 to Q16.16
   always_ff @(posedge clock) begin
      if (cmd.round_en) begin
         rnd_ff <= RND_W'((acc_ff + ROUND_HALF) >>> FRAC_W);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_direct) begin
         out_value_ff  <= '0;
         out_status_ff <= stat.in_grid ? STATUS_OK : STATUS_RANGE;
      end else if (cmd.out_result) begin
         if (rnd_ff > SAT_MAX) begin
            out_value_ff  <= RAIL_MAX;
            out_status_ff <= STATUS_SAT;
         end else if (rnd_ff < SAT_MIN) begin
            out_value_ff  <= RAIL_MIN;
            out_status_ff <= STATUS_SAT;
         end else begin
            out_value_ff  <= rnd_ff[DATA_W-1:0];
            out_status_ff <= STATUS_OK;
         end
      end
   end

   assign rsp_product_value = out_value_ff;
   assign rsp_status        = out_status_ff;

endmodule

[rtl/core/seven_point_stencil_matvec.sv]
// Seven-point symmetric stencil matrix times vector over a 3D grid, Q16.16 fixed point.
// A load transaction writes one cell's value and its diagonal and three upward
// coefficients; a compute transaction returns the matrix row at a cell times the
// vector, rounded half up to Q16.16 and saturated (status 2), or status 1 with a
// zero product for a coordinate outside the grid. One transaction is worked on at
// a time. A compute transaction passes from acceptance to the result register through
// a coordinate check, seven reads of the five cell stores (one stencil point per cycle,
// every store read at the same address), the registered multiplier and accumulator,
// rounding and saturation. A load or an out-of-grid transaction goes from the
// coordinate check straight to the result register. Either waits while an earlier
// result is still held in the output register. The next request is taken the cycle
// after the result is loaded, while that result waits in the output register. The
// stores are not cleared at reset: every cell that a compute transaction touches
// must have been loaded first. The user must write grid counts only while no
// transaction is in flight; the block itself does not enforce this.
module seven_point_stencil_matvec #(
   parameter int MAX_X = 16,
   parameter int MAX_Y = 16,
   parameter int MAX_Z = 16
) (
   input  logic          clock,
   input  logic          reset,
   sps_req_if.sink       req_bus,
   sps_rsp_if.source     rsp_bus,
   sps_csr_if.sink       csr_bus
);
   import sps_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type stat;
   logic          csr_write;

   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   sps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sps_dp #(
      .MAX_X (MAX_X),
      .MAX_Y (MAX_Y),
      .MAX_Z (MAX_Z)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_write         (csr_write),
      .csr_index         (csr_bus.index),
      .csr_data          (csr_bus.data),
      .req_func          (req_bus.func),
      .req_x_coord       (req_bus.x_coord),
      .req_y_coord       (req_bus.y_coord),
      .req_z_coord       (req_bus.z_coord),
      .req_cell_value    (req_bus.cell_value),
      .req_diag_coef     (req_bus.diag_coef),
      .req_up_x_coef     (req_bus.up_x_coef),
      .req_up_y_coef     (req_bus.up_y_coef),
      .req_up_z_coef     (req_bus.up_z_coef),
      .rsp_product_value (rsp_bus.product_value),
      .rsp_status        (rsp_bus.status)
   );

endmodule

[rtl/core/sps_checker.sv]
// port-level assertions for the stencil block, bound to the top level
`include "assert_macros.svh"

module sps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] product_value,
   input logic [1:0]  status
);
   import sps_pkg::*;

   // a stalled response keeps its payload
   `SPS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(product_value) && $stable(status))

   // one transaction at a time: busy right after a request is taken
   `SPS_ASSERT_MSG(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready, "request taken while busy")

   `SPS_ASSERT(a_range_zero, clock, reset, rsp_valid && status == STATUS_RANGE |-> product_value == '0)

   `SPS_ASSERT(a_sat_rails, clock, reset, rsp_valid && status == STATUS_SAT |-> product_value == RAIL_MAX || product_value == RAIL_MIN)

endmodule

bind seven_point_stencil_matvec sps_checker u_sps_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .product_value (rsp_bus.product_value),
   .status        (rsp_bus.status)
);
